/* hw/rtl/atp_pkg.sv */
// Shared constants, types and the rounding multiply for the atan2 pipeline.
package atp_pkg;

    localparam int IN_WIDTH        = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_W           = 16;
    localparam int QF              = 16;
    localparam int Q_W             = 18;
    localparam int R_W             = 20;

    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QF / DIV_BITS;

    localparam int RND_SH   = (ANGLE_FRAC_BITS <= QF) ? (QF - ANGLE_FRAC_BITS) : 0;
    localparam int LSH      = (ANGLE_FRAC_BITS > QF) ? (ANGLE_FRAC_BITS - QF) : 0;
    localparam int RND_HALF = (RND_SH > 0) ? (1 << (RND_SH - 1)) : 0;
    localparam int MAGO_W   = R_W + LSH;
    localparam int OUT_MAX  = 32767;

    localparam logic signed [Q_W-1:0] COEF3 = -18'sd21767;
    localparam logic signed [Q_W-1:0] COEF5 = 18'sd12243;
    localparam logic signed [Q_W-1:0] COEF7 = -18'sd6167;
    localparam logic signed [Q_W-1:0] COEF9 = 18'sd1628;

    localparam int PI_INT = 205887;
    localparam logic signed [R_W-1:0] HALF_PI_Q = 20'sd102944;
    localparam logic signed [R_W-1:0] PI_Q      = 20'sd205887;

    localparam int PI_SCALED = (ANGLE_FRAC_BITS <= QF) ? ((PI_INT + RND_HALF) >> RND_SH)
                                                       : (PI_INT << LSH);
    localparam int ANGLE_LIM = (PI_SCALED > OUT_MAX) ? OUT_MAX : PI_SCALED;

    typedef struct packed {
        logic swap;
        logic xneg;
        logic yneg;
        logic zero;
        logic equal;
    } t_flags;

    typedef struct packed {
        logic [IN_WIDTH-1:0] mn;
        logic [IN_WIDTH-1:0] mx;
        t_flags              flags;
    } t_div_in;

    typedef struct packed {
        logic [QF-1:0] q;
        t_flags        flags;
    } t_ratio;

    typedef struct packed {
        logic signed [Q_W-1:0] r;
        t_flags                flags;
    } t_poly;

    // Q.16 product, rounded half up (floor of prod + half LSB)
    function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                   input logic signed [Q_W-1:0] b);
        logic signed [2*Q_W-1:0] prod;
        prod = a * b;
        prod = prod + (2*Q_W)'(1 << (QF - 1));
        return prod[QF+Q_W-1:QF];
    endfunction

endpackage

/* hw/rtl/atp_if.sv */
// Valid/ready item channels: input vector and output angle.
interface atp_in_if import atp_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [IN_WIDTH-1:0] x_in;
    logic signed [IN_WIDTH-1:0] y_in;

    modport source (output valid, output x_in, output y_in, input ready);
    modport sink   (input valid, input x_in, input y_in, output ready);
endinterface

interface atp_out_if import atp_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

/* hw/rtl/atp_div.sv */
// Pipelined restoring divider: min * 2^16 / max, two quotient bits per stage.
module atp_div import atp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_div_in i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_ratio  o_data
);

    logic [DIV_STAGES-1:0] r_vld;
    logic [DIV_STAGES:0]   w_rdy;
    logic [IN_WIDTH-1:0]   r_rem [DIV_STAGES];
    logic [IN_WIDTH-1:0]   r_mx  [DIV_STAGES];
    logic [QF-1:0]         r_q   [DIV_STAGES];
    t_flags                r_flg [DIV_STAGES];

    assign w_rdy[DIV_STAGES] = i_ready;
    assign o_ready           = w_rdy[0];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                src_v;
        logic [IN_WIDTH-1:0] src_rem;
        logic [IN_WIDTH-1:0] src_mx;
        logic [QF-1:0]       src_q;
        t_flags              src_f;
        logic [IN_WIDTH-1:0] n_rem;
        logic [QF-1:0]       n_q;
        logic [IN_WIDTH-1:0] w_sh;

        if (k == 0) begin : g_first
            assign src_v   = i_valid;
            assign src_rem = i_data.mn;
            assign src_mx  = i_data.mx;
            assign src_q   = '0;
            assign src_f   = i_data.flags;
        end else begin : g_next
            assign src_v   = r_vld[k-1];
            assign src_rem = r_rem[k-1];
            assign src_mx  = r_mx[k-1];
            assign src_q   = r_q[k-1];
            assign src_f   = r_flg[k-1];
        end

        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

        always_comb begin
            n_rem = src_rem;
            n_q   = src_q;
            w_sh  = '0;
            for (int j = 0; j < DIV_BITS; j++) begin
                w_sh = {n_rem[IN_WIDTH-2:0], 1'b0};
                if (w_sh >= src_mx) begin
                    n_rem = w_sh - src_mx;
                    n_q   = {n_q[QF-2:0], 1'b1};
                end else begin
                    n_rem = w_sh;
                    n_q   = {n_q[QF-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[k] && src_v) begin
                r_rem[k] <= n_rem;
                r_mx[k]  <= src_mx;
                r_q[k]   <= n_q;
                r_flg[k] <= src_f;
            end
        end
    end

    assign o_valid      = r_vld[DIV_STAGES-1];
    assign o_data.q     = r_q[DIV_STAGES-1];
    assign o_data.flags = r_flg[DIV_STAGES-1];

endmodule

/* hw/rtl/atp_poly.sv */
// Five-stage odd polynomial: atan(a) = a + a^3 * (C3 + C5 s + C7 s^2 + C9 s^3).
module atp_poly import atp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_ratio i_data,
    output logic   o_valid,
    input  logic   i_ready,
    output t_poly  o_data
);

    localparam int NST = 5;

    logic [NST-1:0] r_vld;
    logic [NST:0]   w_rdy;
    logic [NST-1:0] w_src_v;

    logic [QF-1:0]         w_a0;
    logic [QF-1:0]         r_a0, r_a1, r_a2, r_a3;
    logic signed [Q_W-1:0] r_s0, r_s1, r_s2;
    logic signed [Q_W-1:0] r_p1, r_p2, r_p3, r_sa3, r_r4;
    t_flags                r_f0, r_f1, r_f2, r_f3, r_f4;

    function automatic logic signed [Q_W-1:0] ext_a(input logic [QF-1:0] a);
        return signed'(Q_W'(a));
    endfunction

    assign w_src_v = {r_vld[NST-2:0], i_valid};
    assign w_rdy[NST] = i_ready;
    assign o_ready = w_rdy[0];

    for (genvar k = 0; k < NST; k++) begin : g_ctl
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_rdy[k]) begin
                r_vld[k] <= w_src_v[k];
            end
        end
    end

    // ratio 1.0 saturates to the largest Q0.16 code
    assign w_a0 = i_data.flags.equal ? '1 : i_data.q;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && w_src_v[0]) begin
            r_a0 <= w_a0;
            r_s0 <= qmul(ext_a(w_a0), ext_a(w_a0));
            r_f0 <= i_data.flags;
        end
        if (w_rdy[1] && w_src_v[1]) begin
            r_a1 <= r_a0;
            r_s1 <= r_s0;
            r_p1 <= qmul(COEF9, r_s0) + COEF7;
            r_f1 <= r_f0;
        end
        if (w_rdy[2] && w_src_v[2]) begin
            r_a2 <= r_a1;
            r_s2 <= r_s1;
            r_p2 <= qmul(r_p1, r_s1) + COEF5;
            r_f2 <= r_f1;
        end
        if (w_rdy[3] && w_src_v[3]) begin
            r_a3  <= r_a2;
            r_sa3 <= qmul(r_s2, ext_a(r_a2));
            r_p3  <= qmul(r_p2, r_s2) + COEF3;
            r_f3  <= r_f2;
        end
        if (w_rdy[4] && w_src_v[4]) begin
            r_r4 <= qmul(r_p3, r_sa3) + ext_a(r_a3);
            r_f4 <= r_f3;
        end
    end

    assign o_valid      = r_vld[NST-1];
    assign o_data.r     = r_r4;
    assign o_data.flags = r_f4;

endmodule

/* hw/rtl/atan2_poly_approx.sv */
// Top level: magnitude/octant front end, divider, polynomial, reflect and round.
//
//   channel  | dir | payload                         | handshake
//   i_in     | in  | x_in, y_in  signed 16-bit       | valid/ready
//   o_out    | out | angle signed Q3.13 radians      | valid/ready
//
// One item per cycle sustained while o_out is not stalled; stages: front end 1,
// divider 8 (two quotient bits per stage), polynomial 5, output register 1.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage holds its item while the next one is full and stalled, so a
// stall on o_out backs up stage by stage and never drops or repeats an item.
module atan2_poly_approx import atp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    atp_in_if.sink  i_in,
    atp_out_if.source o_out
);

    logic [IN_WIDTH-1:0] w_ax, w_ay;
    t_div_in             n_f_data, r_f_data;
    logic                r_f_vld;
    logic                w_f_rdy;
    logic                w_div_rdy;

    logic   w_div_vld;
    t_ratio w_ratio;
    logic   w_poly_rdy;
    logic   w_poly_vld;
    t_poly  w_poly;
    logic   w_o_rdy;

    logic signed [R_W-1:0]   w_t;
    logic [MAGO_W-1:0]       w_mag;
    logic signed [OUT_W-1:0] n_angle;
    logic signed [OUT_W-1:0] r_angle;
    logic                    r_ovld;

    // front end: magnitudes and octant
    assign w_ax = i_in.x_in[IN_WIDTH-1] ? IN_WIDTH'(~i_in.x_in + 1'b1) : IN_WIDTH'(i_in.x_in);
    assign w_ay = i_in.y_in[IN_WIDTH-1] ? IN_WIDTH'(~i_in.y_in + 1'b1) : IN_WIDTH'(i_in.y_in);

    always_comb begin
        n_f_data.flags.swap  = w_ay > w_ax;
        n_f_data.flags.xneg  = i_in.x_in[IN_WIDTH-1];
        n_f_data.flags.yneg  = i_in.y_in[IN_WIDTH-1];
        n_f_data.flags.equal = w_ax == w_ay;
        n_f_data.mx          = (w_ay > w_ax) ? w_ay : w_ax;
        n_f_data.mn          = (w_ay > w_ax) ? w_ax : w_ay;
        n_f_data.flags.zero  = n_f_data.mx == '0;
    end

    assign w_f_rdy    = !r_f_vld || w_div_rdy;
    assign i_in.ready = w_f_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_f_rdy) begin
            r_f_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_f_rdy && i_in.valid) begin
            r_f_data <= n_f_data;
        end
    end

    atp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_vld),
        .o_ready (w_div_rdy),
        .i_data  (r_f_data),
        .o_valid (w_div_vld),
        .i_ready (w_poly_rdy),
        .o_data  (w_ratio)
    );

    atp_poly u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_div_vld),
        .o_ready (w_poly_rdy),
        .i_data  (w_ratio),
        .o_valid (w_poly_vld),
        .i_ready (w_o_rdy),
        .o_data  (w_poly)
    );

    // reflect into the right octant, round to the output format, apply sign; a zero vector gives 0
    always_comb begin
        w_t = R_W'(w_poly.r);
        if (w_t < 0) begin
            w_t = '0;
        end
        if (w_poly.flags.swap) begin
            w_t = HALF_PI_Q - w_t;
        end
        if (w_poly.flags.xneg) begin
            w_t = PI_Q - w_t;
        end
        if (w_t < 0) begin
            w_t = '0;
        end
        w_mag = MAGO_W'(unsigned'(w_t));
        w_mag = (w_mag + MAGO_W'(RND_HALF)) >> RND_SH;
        w_mag = w_mag << LSH;
        if (w_mag > MAGO_W'(OUT_MAX)) begin
            w_mag = MAGO_W'(OUT_MAX);
        end
        n_angle = signed'(OUT_W'(w_mag));
        if (w_poly.flags.yneg) begin
            n_angle = -n_angle;
        end
        if (w_poly.flags.zero) begin
            n_angle = '0;
        end
    end

    assign w_o_rdy = !r_ovld || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_o_rdy) begin
            r_ovld <= w_poly_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_o_rdy && w_poly_vld) begin
            r_angle <= n_angle;
        end
    end

    assign o_out.valid = r_ovld;
    assign o_out.angle = r_angle;

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_angle <= OUT_W'(ANGLE_LIM)) && (r_angle >= -OUT_W'(ANGLE_LIM)))
        else $error("angle outside -pi..pi");

    a_front_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_f_vld && !w_div_rdy |=> r_f_vld && $stable(r_f_data))
        else $error("front-end item changed while stalled");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_f_vld |-> i_in.ready)
        else $error("input not ready with empty front stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_poly_vld && !w_o_rdy |=> w_poly_vld && $stable(w_poly))
        else $error("polynomial result changed while output stalled");

endmodule
